>>> rtl/core/vna_pkg.sv
// Shared types and constants for the vertex normal accumulator.
// Request and response beat layouts, request codes, normalizer interface.
// No dependencies.
`timescale 1ns / 1ps

package vna_pkg;

    localparam int IDX_W   = 10;
    localparam int POS_W   = 16;
    localparam int EDGE_W  = 17;
    localparam int PROD_W  = 34;
    localparam int CROSS_W = 35;
    localparam int ACC_W   = 40;
    localparam int NRM_W   = 16;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_TRI   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]              req_type;
        logic [IDX_W-1:0]        vertex_a;
        logic [IDX_W-1:0]        vertex_b;
        logic [IDX_W-1:0]        vertex_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]        vertex_index;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic                    degenerate;
    } rsp_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] vx;
        logic signed [ACC_W-1:0] vy;
        logic signed [ACC_W-1:0] vz;
    } norm_cmd_t;

    typedef struct packed {
        logic                    done;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic                    degen;
    } norm_res_t;

endpackage

>>> rtl/core/vna_norm.sv
// Iterative vector normalizer: scale to 24 bits, sum of squares, bit-serial
// square root and restoring divide, one step per cycle. Uses vna_pkg.
`timescale 1ns / 1ps

module vna_norm
(
    input  logic                clk,
    input  logic                rst_n,
    input  vna_pkg::norm_cmd_t  cmd,
    output vna_pkg::norm_res_t  res
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_DLOAD = 3'd4;
    localparam logic [2:0] N_DSTEP = 3'd5;
    localparam logic [2:0] N_DONE  = 3'd6;

    logic [2:0]  state_reg;
    logic [39:0] mag_reg [3];
    logic [2:0]  neg_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  ci_reg;
    logic [49:0] s_reg;
    logic [47:0] prod_reg;
    logic [49:0] rem_reg;
    logic [49:0] root_reg;
    logic [49:0] bit_reg;
    logic [24:0] drem_reg;
    logic [14:0] nlo_reg;
    logic [14:0] q_reg;
    logic signed [15:0] out_reg [3];
    logic        degen_reg;

    logic [39:0] max01;
    logic [39:0] maxv;
    logic [23:0] sq_op;
    logic [49:0] trial;
    logic [24:0] root;
    logic [38:0] num;
    logic [25:0] dtrial;
    logic        qbit;
    logic [14:0] qfull;
    logic [15:0] qext;

    function automatic logic [39:0] abs40(input logic signed [39:0] v);
        abs40 = v[39] ? (~v + 40'd1) : v;
    endfunction

    assign max01 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
    assign maxv  = (max01 > mag_reg[2]) ? max01 : mag_reg[2];
    assign trial = root_reg + bit_reg;
    assign root  = root_reg[24:0];
    assign num   = {1'b0, mag_reg[ci_reg][23:0], 14'd0} + {15'd0, root[24:1]};
    assign dtrial = {drem_reg, nlo_reg[14]};
    assign qbit  = dtrial >= {1'b0, root};
    assign qfull = {q_reg[13:0], qbit};
    assign qext  = neg_reg[ci_reg] ? (16'd0 - {1'b0, qfull}) : {1'b0, qfull};

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    sq_op = mag_reg[0][23:0];
            2'd1:    sq_op = mag_reg[1][23:0];
            default: sq_op = mag_reg[2][23:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            unique case (state_reg)
                N_IDLE:
                begin
                    if (cmd.start)
                    begin
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    if (maxv == 40'd0)
                    begin
                        state_reg <= N_DONE;
                    end
                    else if (maxv[39:24] == 16'd0 && maxv[23])
                    begin
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    if (cnt_reg == 5'd3)
                    begin
                        state_reg <= N_SQRT;
                    end
                end
                N_SQRT:
                begin
                    if (cnt_reg == 5'd24)
                    begin
                        state_reg <= N_DLOAD;
                    end
                end
                N_DLOAD:
                begin
                    state_reg <= N_DSTEP;
                end
                N_DSTEP:
                begin
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= (ci_reg == 2'd2) ? N_DONE : N_DLOAD;
                    end
                end
                N_DONE:
                begin
                    state_reg <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                mag_reg[0] <= abs40(cmd.vx);
                mag_reg[1] <= abs40(cmd.vy);
                mag_reg[2] <= abs40(cmd.vz);
                neg_reg    <= {cmd.vz[39], cmd.vy[39], cmd.vx[39]};
                degen_reg  <= 1'b0;
            end
            N_SHIFT:
            begin
                cnt_reg <= 5'd0;
                s_reg   <= 50'd0;
                if (maxv == 40'd0)
                begin
                    degen_reg  <= 1'b1;
                    out_reg[0] <= 16'sd0;
                    out_reg[1] <= 16'sd0;
                    out_reg[2] <= 16'sd0;
                end
                else if (maxv[39:24] != 16'd0)
                begin
                    // truncate one bit at a time until the largest fits 24 bits
                    mag_reg[0] <= mag_reg[0] >> 1;
                    mag_reg[1] <= mag_reg[1] >> 1;
                    mag_reg[2] <= mag_reg[2] >> 1;
                end
                else if (!maxv[23])
                begin
                    mag_reg[0] <= mag_reg[0] << 1;
                    mag_reg[1] <= mag_reg[1] << 1;
                    mag_reg[2] <= mag_reg[2] << 1;
                end
            end
            N_SQ:
            begin
                prod_reg <= sq_op * sq_op;
                if (cnt_reg != 5'd0)
                begin
                    s_reg <= s_reg + {2'd0, prod_reg};
                end
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    rem_reg  <= s_reg + {2'd0, prod_reg};
                    root_reg <= 50'd0;
                    bit_reg  <= 50'd1 << 48;
                    cnt_reg  <= 5'd0;
                end
            end
            N_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
                ci_reg  <= 2'd0;
            end
            N_DLOAD:
            begin
                drem_reg <= {1'b0, num[38:15]};
                nlo_reg  <= num[14:0];
                q_reg    <= 15'd0;
                cnt_reg  <= 5'd14;
            end
            N_DSTEP:
            begin
                drem_reg <= qbit ? 25'(dtrial - {1'b0, root}) : dtrial[24:0];
                nlo_reg  <= {nlo_reg[13:0], 1'b0};
                q_reg    <= qfull;
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    out_reg[ci_reg] <= qext;
                    ci_reg          <= ci_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.done  = state_reg == N_DONE;
    assign res.nx    = out_reg[0];
    assign res.ny    = out_reg[1];
    assign res.nz    = out_reg[2];
    assign res.degen = degen_reg;

endmodule

>>> rtl/core/vertex_normal_accumulator.sv
// Top level of the vertex normal accumulator: sequencer, position and sum
// memories, shared cross-product multiplier. Uses vna_pkg and vna_norm.
`timescale 1ns / 1ps

// Smooth vertex normals in fixed point. A request beat is taken when start is
// high and busy is low; only query beats give a response, shown for one cycle
// with done high, and the receiver cannot stall it. After reset the block
// clears the sum memory one entry a cycle with busy high. A triangle does
// three position reads, six products through one 17x17 multiplier and
// three read-modify-writes of the sum memory. A query runs the bit-serial
// square root and three 15-step divides in the normalizer, taking longer
// the further the largest sum component must be scaled, and skips both
// when the sum is zero. With MAX_VERTICES below 1024 each index is folded
// by repeated subtraction.
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = 1024
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  vna_pkg::req_t  req,
    output logic           busy,
    output logic           done,
    output vna_pkg::rsp_t  rsp
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);
    localparam logic [9:0] FOLD = 10'(MAX_VERTICES);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_REDUCE = 4'd2;
    localparam logic [3:0] ST_LOAD   = 4'd3;
    localparam logic [3:0] ST_RB     = 4'd4;
    localparam logic [3:0] ST_RA     = 4'd5;
    localparam logic [3:0] ST_RC     = 4'd6;
    localparam logic [3:0] ST_E2     = 4'd7;
    localparam logic [3:0] ST_MUL    = 4'd8;
    localparam logic [3:0] ST_CROSS  = 4'd9;
    localparam logic [3:0] ST_ARD    = 4'd10;
    localparam logic [3:0] ST_AWR    = 4'd11;
    localparam logic [3:0] ST_QRD    = 4'd12;
    localparam logic [3:0] ST_QWAIT  = 4'd13;
    localparam logic [3:0] ST_QNORM  = 4'd14;

    logic [3:0]    state_reg;
    logic [3:0]    state_next;
    vna_pkg::req_t req_reg;
    logic [9:0]    ia_reg;
    logic [9:0]    ib_reg;
    logic [9:0]    ic_reg;
    logic [AW-1:0] clr_reg;
    logic [2:0]    mcnt_reg;
    logic [1:0]    corner_reg;
    logic          done_reg;
    vna_pkg::rsp_t rsp_reg;

    logic signed [16:0] e1x_reg, e1y_reg, e1z_reg;
    logic signed [16:0] e2x_reg, e2y_reg, e2z_reg;
    logic signed [33:0] p_reg [6];
    logic signed [34:0] nx_reg, ny_reg, nz_reg;

    logic [47:0]  pos_mem [MAX_VERTICES];
    logic [119:0] sum_mem [MAX_VERTICES];
    logic [47:0]  pos_rdata;
    logic [119:0] sum_rdata;
    logic [AW-1:0] pos_raddr;
    logic [AW-1:0] sum_raddr;
    logic [AW-1:0] sum_waddr;
    logic [119:0]  sum_wdata;
    logic          sum_we;
    logic [AW-1:0] corner_addr;

    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;
    logic               fold_any;

    vna_pkg::norm_cmd_t norm_cmd;
    vna_pkg::norm_res_t norm_res;

    function automatic logic signed [39:0] sat_add(input logic signed [39:0] acc,
                                                   input logic signed [34:0] d);
        logic signed [40:0] s;
        s = {acc[39], acc} + {{6{d[34]}}, d};
        if (s[40] != s[39])
        begin
            sat_add = s[40] ? vna_pkg::ACC_MIN : vna_pkg::ACC_MAX;
        end
        else
        begin
            sat_add = s[39:0];
        end
    endfunction

    assign fold_any = (ia_reg >= FOLD || ib_reg >= FOLD || ic_reg >= FOLD)
                      && (MAX_VERTICES < 1024);

    always_comb
    begin
        unique case (corner_reg)
            2'd0:    corner_addr = AW'(ia_reg);
            2'd1:    corner_addr = AW'(ib_reg);
            default: corner_addr = AW'(ic_reg);
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_RB:   pos_raddr = AW'(ib_reg);
            ST_RA:   pos_raddr = AW'(ia_reg);
            default: pos_raddr = AW'(ic_reg);
        endcase
        sum_raddr = (state_reg == ST_QRD) ? AW'(ia_reg) : corner_addr;
    end

    always_comb
    begin
        sum_we    = 1'b0;
        sum_waddr = corner_addr;
        sum_wdata = {sat_add(sum_rdata[119:80], nz_reg),
                     sat_add(sum_rdata[79:40], ny_reg),
                     sat_add(sum_rdata[39:0], nx_reg)};
        priority if (state_reg == ST_CLEAR)
        begin
            sum_we    = 1'b1;
            sum_waddr = clr_reg;
            sum_wdata = '0;
        end
        else if (state_reg == ST_LOAD)
        begin
            sum_we    = 1'b1;
            sum_waddr = AW'(ia_reg);
            sum_wdata = '0;
        end
        else if (state_reg == ST_AWR)
        begin
            sum_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            pos_mem[AW'(ia_reg)] <= {req_reg.pos_z, req_reg.pos_y, req_reg.pos_x};
        end
        pos_rdata <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_rdata <= sum_mem[sum_raddr];
    end

    always_comb
    begin
        unique case (mcnt_reg)
            3'd0:    begin mul_a = e1y_reg; mul_b = e2z_reg; end
            3'd1:    begin mul_a = e1z_reg; mul_b = e2y_reg; end
            3'd2:    begin mul_a = e1z_reg; mul_b = e2x_reg; end
            3'd3:    begin mul_a = e1x_reg; mul_b = e2z_reg; end
            3'd4:    begin mul_a = e1x_reg; mul_b = e2y_reg; end
            default: begin mul_a = e1y_reg; mul_b = e2x_reg; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (start && req.req_type != vna_pkg::REQ_RSVD)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (!fold_any)
                begin
                    unique case (req_reg.req_type)
                        vna_pkg::REQ_LOAD: state_next = ST_LOAD;
                        vna_pkg::REQ_TRI:  state_next = ST_RB;
                        default:           state_next = ST_QRD;
                    endcase
                end
            end
            ST_LOAD:   state_next = ST_IDLE;
            ST_RB:     state_next = ST_RA;
            ST_RA:     state_next = ST_RC;
            ST_RC:     state_next = ST_E2;
            ST_E2:     state_next = ST_MUL;
            ST_MUL:    if (mcnt_reg == 3'd5) state_next = ST_CROSS;
            ST_CROSS:  state_next = ST_ARD;
            ST_ARD:    state_next = ST_AWR;
            ST_AWR:    state_next = (corner_reg == 2'd2) ? ST_IDLE : ST_ARD;
            ST_QRD:    state_next = ST_QWAIT;
            ST_QWAIT:  state_next = ST_QNORM;
            ST_QNORM:  if (norm_res.done) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == ST_QNORM && norm_res.done;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                req_reg <= req;
                ia_reg  <= req.vertex_a;
                ib_reg  <= req.vertex_b;
                ic_reg  <= req.vertex_c;
            end
            ST_REDUCE:
            begin
                // fold indexes into the table one subtraction per cycle
                if (ia_reg >= FOLD && MAX_VERTICES < 1024) ia_reg <= ia_reg - FOLD;
                if (ib_reg >= FOLD && MAX_VERTICES < 1024) ib_reg <= ib_reg - FOLD;
                if (ic_reg >= FOLD && MAX_VERTICES < 1024) ic_reg <= ic_reg - FOLD;
            end
            ST_RA:
            begin
                e2x_reg <= {pos_rdata[15], pos_rdata[15:0]};
                e2y_reg <= {pos_rdata[31], pos_rdata[31:16]};
                e2z_reg <= {pos_rdata[47], pos_rdata[47:32]};
            end
            ST_RC:
            begin
                e1x_reg <= {pos_rdata[15], pos_rdata[15:0]} - e2x_reg;
                e1y_reg <= {pos_rdata[31], pos_rdata[31:16]} - e2y_reg;
                e1z_reg <= {pos_rdata[47], pos_rdata[47:32]} - e2z_reg;
            end
            ST_E2:
            begin
                e2x_reg  <= {pos_rdata[15], pos_rdata[15:0]} - e2x_reg;
                e2y_reg  <= {pos_rdata[31], pos_rdata[31:16]} - e2y_reg;
                e2z_reg  <= {pos_rdata[47], pos_rdata[47:32]} - e2z_reg;
                mcnt_reg <= 3'd0;
            end
            ST_MUL:
            begin
                p_reg[mcnt_reg] <= mul_p;
                mcnt_reg        <= mcnt_reg + 3'd1;
            end
            ST_CROSS:
            begin
                nx_reg <= {p_reg[0][33], p_reg[0]} - {p_reg[1][33], p_reg[1]};
                ny_reg <= {p_reg[2][33], p_reg[2]} - {p_reg[3][33], p_reg[3]};
                nz_reg <= {p_reg[4][33], p_reg[4]} - {p_reg[5][33], p_reg[5]};
                corner_reg <= 2'd0;
            end
            ST_AWR:
            begin
                corner_reg <= corner_reg + 2'd1;
            end
            ST_QNORM:
            begin
                rsp_reg.vertex_index <= req_reg.vertex_a;
                rsp_reg.normal_x     <= norm_res.nx;
                rsp_reg.normal_y     <= norm_res.ny;
                rsp_reg.normal_z     <= norm_res.nz;
                rsp_reg.degenerate   <= norm_res.degen;
            end
            default:
            begin
            end
        endcase
    end

    assign norm_cmd.start = state_reg == ST_QWAIT;
    assign norm_cmd.vx    = sum_rdata[39:0];
    assign norm_cmd.vy    = sum_rdata[79:40];
    assign norm_cmd.vz    = sum_rdata[119:80];

    vna_norm u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (norm_cmd),
        .res   (norm_res)
    );

    assign busy = state_reg != ST_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTH
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("response strobe held longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response while sequencer busy");

    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("response right after a request beat");

    a_norm_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        norm_cmd.start |-> req_reg.req_type == vna_pkg::REQ_QUERY)
        else $error("normalizer started for a non-query request");
`endif

endmodule

>>> bench/vna_checker.sv
// Checker for the vertex normal accumulator: watches request and response beats,
// predicts query results from its own copy of positions and sums, compares them.
// Depends on vna_pkg.
`timescale 1ns / 1ps

module vna_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  vna_pkg::req_t  req,
    input  logic           done,
    input  vna_pkg::rsp_t  rsp,
    output int             errors,
    output int             pending
);

    localparam int NV = 1024;

    logic signed [vna_pkg::POS_W-1:0] pos_x_mem [NV];
    logic signed [vna_pkg::POS_W-1:0] pos_y_mem [NV];
    logic signed [vna_pkg::POS_W-1:0] pos_z_mem [NV];
    logic signed [63:0]      acc_x [NV];
    logic signed [63:0]      acc_y [NV];
    logic signed [63:0]      acc_z [NV];
    vna_pkg::rsp_t           normals_due [$];

    function automatic logic signed [63:0] sat40(input logic signed [63:0] s);
        if (s > 64'sd549755813887)
            return 64'sd549755813887;
        if (s < -64'sd549755813888)
            return -64'sd549755813888;
        return s;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic vna_pkg::rsp_t unit_normal(input logic [vna_pkg::IDX_W-1:0] idx);
        logic signed [63:0] v [3];
        logic [63:0]        mag [3];
        logic [63:0]        m;
        logic [63:0]        s;
        logic [63:0]        r;
        logic [63:0]        q;
        logic [15:0]        o [3];
        int                 len;
        vna_pkg::rsp_t      p;
        v[0] = acc_x[idx];
        v[1] = acc_y[idx];
        v[2] = acc_z[idx];
        m = '0;
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > m)
                m = mag[i];
        end
        p.vertex_index = idx;
        if (m == 0)
        begin
            p.normal_x = '0;
            p.normal_y = '0;
            p.normal_z = '0;
            p.degenerate = 1'b1;
            return p;
        end
        len = 0;
        while (len < 64 && (m >> len) != 0)
            len++;
        for (int i = 0; i < 3; i++)
        begin
            if (len > 24)
                mag[i] = mag[i] >> (len - 24);
            else
                mag[i] = mag[i] << (24 - len);
            s += mag[i] * mag[i];
        end
        r = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] * 64'd16384 + (r >> 1)) / r;
            if (v[i] < 0)
                q = -q;
            o[i] = q[15:0];
        end
        p.normal_x = o[0];
        p.normal_y = o[1];
        p.normal_z = o[2];
        p.degenerate = 1'b0;
        return p;
    endfunction

    task automatic apply_beat(input vna_pkg::req_t r);
        logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        logic [vna_pkg::IDX_W-1:0] corner [3];
        unique case (r.req_type)
            vna_pkg::REQ_LOAD:
            begin
                pos_x_mem[r.vertex_a] = r.pos_x;
                pos_y_mem[r.vertex_a] = r.pos_y;
                pos_z_mem[r.vertex_a] = r.pos_z;
                acc_x[r.vertex_a] = '0;
                acc_y[r.vertex_a] = '0;
                acc_z[r.vertex_a] = '0;
            end
            vna_pkg::REQ_TRI:
            begin
                e1x = pos_x_mem[r.vertex_a] - pos_x_mem[r.vertex_b];
                e1y = pos_y_mem[r.vertex_a] - pos_y_mem[r.vertex_b];
                e1z = pos_z_mem[r.vertex_a] - pos_z_mem[r.vertex_b];
                e2x = pos_x_mem[r.vertex_c] - pos_x_mem[r.vertex_b];
                e2y = pos_y_mem[r.vertex_c] - pos_y_mem[r.vertex_b];
                e2z = pos_z_mem[r.vertex_c] - pos_z_mem[r.vertex_b];
                nx = e1y * e2z - e1z * e2y;
                ny = e1z * e2x - e1x * e2z;
                nz = e1x * e2y - e1y * e2x;
                corner[0] = r.vertex_a;
                corner[1] = r.vertex_b;
                corner[2] = r.vertex_c;
                for (int i = 0; i < 3; i++)
                begin
                    acc_x[corner[i]] = sat40(acc_x[corner[i]] + nx);
                    acc_y[corner[i]] = sat40(acc_y[corner[i]] + ny);
                    acc_z[corner[i]] = sat40(acc_z[corner[i]] + nz);
                end
            end
            vna_pkg::REQ_QUERY:
                normals_due = {normals_due, unit_normal(r.vertex_a)};
            default: ;
        endcase
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        for (int i = 0; i < NV; i++)
        begin
            pos_x_mem[i] = '0;
            pos_y_mem[i] = '0;
            pos_z_mem[i] = '0;
            acc_x[i] = '0;
            acc_y[i] = '0;
            acc_z[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        vna_pkg::rsp_t want;
        if (rst_n)
        begin
            // response first: a beat taken this edge cannot have its answer yet
            if (done)
            begin
                if (normals_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response, expected none, actual %p", $time, rsp);
                end
                else
                begin
                    want = normals_due.pop_front();
                    if (rsp !== want)
                    begin
                        errors++;
                        $display("%0t: normal mismatch, expected %p, actual %p",
                                 $time, want, rsp);
                    end
                end
            end
            if (start && !busy)
                apply_beat(req);
        end
        pending = normals_due.size();
    end

endmodule

>>> bench/tb_vertex_normal_accumulator.sv
// Testbench top for the vertex normal accumulator: drives request beats with
// random gaps and gives the verdict. Uses vna_pkg, vna_checker and the block.
`timescale 1ns / 1ps

module tb_vertex_normal_accumulator;

    localparam int NV        = 1024;
    localparam int STALL_MAX = 20000;

    logic          clk;
    logic          rst_n;
    logic          start;
    vna_pkg::req_t req;
    logic          busy;
    logic          done;
    vna_pkg::rsp_t rsp;
    int   errors;
    int   pending;
    int   idle_cycles;
    bit   loaded [NV];
    logic [vna_pkg::IDX_W-1:0] loaded_list [$];

    vertex_normal_accumulator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    vna_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: cycles with no beat accepted either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX)
        begin
            $display("[vertex_normal_accumulator] ERROR");
            $finish;
        end
    end

    // start is already low here; keep it low for a random idle gap before the next beat
    task automatic idle_gap();
        int n;
        n = 1;
        if ($urandom_range(2, 0) != 0)
            n = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 10)
                                            : $urandom_range(3, 1) + 1;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_beat(input vna_pkg::req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (r.req_type == vna_pkg::REQ_LOAD && !loaded[r.vertex_a])
        begin
            loaded[r.vertex_a] = 1'b1;
            loaded_list = {loaded_list, r.vertex_a};
        end
        start <= 1'b0;
        idle_gap();
    endtask

    function automatic logic [vna_pkg::IDX_W-1:0] some_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1, 0)];
    endfunction

    task automatic load(input int v, input int x, input int y, input int z);
        vna_pkg::req_t r;
        r = {$urandom, $urandom, 16'($urandom)};
        r.req_type = vna_pkg::REQ_LOAD;
        r.vertex_a = v[vna_pkg::IDX_W-1:0];
        r.pos_x = x[vna_pkg::POS_W-1:0];
        r.pos_y = y[vna_pkg::POS_W-1:0];
        r.pos_z = z[vna_pkg::POS_W-1:0];
        send_beat(r);
    endtask

    task automatic triangle(input int a, input int b, input int c);
        vna_pkg::req_t r;
        r = {$urandom, $urandom, 16'($urandom)};
        r.req_type = vna_pkg::REQ_TRI;
        r.vertex_a = a[vna_pkg::IDX_W-1:0];
        r.vertex_b = b[vna_pkg::IDX_W-1:0];
        r.vertex_c = c[vna_pkg::IDX_W-1:0];
        send_beat(r);
    endtask

    task automatic query(input int v);
        vna_pkg::req_t r;
        r = {$urandom, $urandom, 16'($urandom)};
        r.req_type = vna_pkg::REQ_QUERY;
        r.vertex_a = v[vna_pkg::IDX_W-1:0];
        send_beat(r);
    endtask

    function automatic int rand_pos();
        case ($urandom_range(3, 0))
            0: return $urandom_range(1, 0) ? 32767 : -32768;
            1: return int'($urandom_range(8191, 0)) - 4096;
            default: return int'($urandom_range(65535, 0)) - 32768;
        endcase
    endfunction

    initial
    begin
        vna_pkg::req_t r;
        int   k;
        start = 1'b0;
        req = '0;
        idle_cycles = 0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, repeated corners, zero sum, repeated triangles, unused code
        load(0, 32767, -32768, 0);
        load(1023, -32768, 32767, 32767);
        load(512, 0, 0, -32768);
        query(0);
        triangle(0, 1023, 512);
        query(0);
        query(1023);
        query(512);
        triangle(0, 0, 1023);
        query(0);
        r = '1;
        send_beat(r);
        // repeat one triangle to grow the sums at its corners, short of saturation
        for (int i = 0; i < 10; i++)
            triangle(0, 1023, 512);
        query(512);
        triangle(512, 1023, 0);
        query(1023);
        load(0, 1, 0, 0);
        query(0);
        // hold off until every answer is back
        while (pending != 0)
            @(posedge clk);

        for (int i = 0; i < 480; i++)
        begin
            k = $urandom_range(99, 0);
            if (loaded_list.size() < 3 || k < 20)
                load($urandom_range(NV - 1, 0), rand_pos(), rand_pos(), rand_pos());
            else if (k < 60)
                triangle(some_loaded(), some_loaded(), some_loaded());
            else if (k < 63)
            begin
                r = {$urandom, $urandom, 16'($urandom)};
                r.req_type = vna_pkg::REQ_RSVD;
                send_beat(r);
            end
            else if (k < 95)
                query(some_loaded());
            else
                // query a loaded vertex or any vertex at all
                query($urandom_range(1, 0) ? some_loaded() : $urandom_range(NV - 1, 0));
        end

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("[vertex_normal_accumulator] OK");
        else
            $display("[vertex_normal_accumulator] ERROR");
        $finish;
    end

endmodule
